// ===== rtl/rsc_pkg.sv =====
package rsc_pkg;

  // Width of the value accumulator; the whole datapath follows from it (8..64).
  localparam int VALUE_WIDTH = 64;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 8;
  localparam int STAT_W      = 2;
  localparam int DIG_IDX_W   = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int CFG_IDX_W   = 2;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_TEN = BASE_W'(10);

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEST_BASE   = CFG_IDX_W'(1);

  localparam logic [STAT_W-1:0] STAT_OK       = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_BAD_CHAR = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = STAT_W'(2);

  // One classified character on its way from the front to the back.
  typedef struct packed {
    logic [BASE_W-1:0] digit;
    logic              bad;
    logic              last;
  } rsc_item_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

endpackage

// ===== rtl/radix_string_converter_core.sv =====
// Radix string converter core.
// Input channel: one ASCII character per transfer (in_char) with in_last on
// the final character of a number. A transfer happens when in_push is high
// and in_full is low. Characters are checked against the source base and fed
// through a four-entry queue into a multiply-add accumulator of VALUE_WIDTH
// bits, one character per cycle while the accumulator is free.
// Result channel: out_char/out_last/out_status hold the oldest result while
// out_empty is low; it transfers when out_pop is high. A good number yields
// its digits in the destination base, most significant first, uppercase;
// zero yields "0". A bad character or an overflow yields one result with
// out_char 0, out_last 1 and the status code.
// Conversion after the last character: the divider finds each output digit
// one quotient bit per cycle and stores it in the digit buffer; then each digit
// is read from the buffer and loaded into the output register. The front keeps
// taking characters into the queue meanwhile; in_full rises when it fills.
// A stalled receiver holds the output register and the back end waits.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_idx
// (0 source base, 1 destination base); write only while idle.
// Reset: synchronous, rst_n low; bases go to 10 and 16, the run clears.
module radix_string_converter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [rsc_pkg::CHAR_W-1:0]    in_char,
  input  logic                          in_last,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [rsc_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last,
  output logic [rsc_pkg::STAT_W-1:0]    out_status,
  input  logic                          cfg_we,
  input  logic [rsc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rsc_pkg::BASE_W-1:0]    cfg_wdata
);

  logic [rsc_pkg::BASE_W-1:0] source_base_r;
  logic [rsc_pkg::BASE_W-1:0] dest_base_r;
  rsc_pkg::rsc_item_t         front_item;
  rsc_pkg::rsc_item_t         back_item;
  logic                       q_empty;
  logic                       q_pop;

  // Hold the base registers; drop writes to indexes past the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_base_r <= rsc_pkg::BASE_W'(10);
      dest_base_r   <= rsc_pkg::BASE_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rsc_pkg::REG_SOURCE_BASE: source_base_r <= cfg_wdata;
        rsc_pkg::REG_DEST_BASE:   dest_base_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify each character as it arrives.
  rsc_front u_front (
    .in_char     (in_char),
    .in_last     (in_last),
    .source_base (source_base_r),
    .item        (front_item)
  );

  // Decouple the front from the accumulator and converter.
  rsc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_item (front_item),
    .full    (in_full),
    .pop     (q_pop),
    .rd_item (back_item),
    .empty   (q_empty)
  );

  // Accumulate, convert and emit.
  rsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (back_item),
    .item_empty  (q_empty),
    .item_pop    (q_pop),
    .source_base (source_base_r),
    .dest_base   (dest_base_r),
    .out_char    (out_char),
    .out_last    (out_last),
    .out_status  (out_status),
    .out_empty   (out_empty),
    .out_pop     (out_pop)
  );

endmodule

// ===== rtl/rsc_front.sv =====
module rsc_front (
  input  logic [rsc_pkg::CHAR_W-1:0] in_char,
  input  logic                       in_last,
  input  logic [rsc_pkg::BASE_W-1:0] source_base,
  output rsc_pkg::rsc_item_t         item
);

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;

  logic [rsc_pkg::BASE_W-1:0] sb;
  logic [7:0]                 lim;

  assign sb  = rsc_pkg::clamp_base(source_base);
  assign lim = CH_0 + {2'b00, sb};

  // Small bases take plain digits below the base; from ten up any
  // alphanumeric passes, letters count ten and up.
  always_comb begin
    item.last  = in_last;
    item.bad   = 1'b0;
    item.digit = '0;
    if (sb < rsc_pkg::BASE_TEN) begin
      if (in_char >= CH_0 && in_char < lim) item.digit = 6'(in_char - CH_0);
      else item.bad = 1'b1;
    end else if (in_char >= CH_0 && in_char <= CH_9) begin
      item.digit = 6'(in_char - CH_0);
    end else if (in_char >= CH_LA && in_char <= CH_LZ) begin
      item.digit = 6'(in_char - CH_LA) + 6'd10;
    end else if (in_char >= CH_UA && in_char <= CH_UZ) begin
      item.digit = 6'(in_char - CH_UA) + 6'd10;
    end else begin
      item.bad = 1'b1;
    end
  end

endmodule

// ===== rtl/rsc_fifo.sv =====
module rsc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rsc_pkg::rsc_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output rsc_pkg::rsc_item_t rd_item,
  output logic               empty
);

  rsc_pkg::rsc_item_t               mem_r [rsc_pkg::QDEPTH];
  logic [rsc_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [rsc_pkg::QCNT_W-1:0]       count_r;
  logic                             do_push, do_pop;

  assign full    = (count_r == rsc_pkg::QCNT_W'(rsc_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/rsc_back.sv =====
module rsc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsc_pkg::rsc_item_t         item,
  input  logic                       item_empty,
  output logic                       item_pop,
  input  logic [rsc_pkg::BASE_W-1:0] source_base,
  input  logic [rsc_pkg::BASE_W-1:0] dest_base,
  output logic [rsc_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last,
  output logic [rsc_pkg::STAT_W-1:0] out_status,
  output logic                       out_empty,
  input  logic                       out_pop
);

  localparam int W  = rsc_pkg::VALUE_WIDTH;
  localparam int BW = rsc_pkg::BASE_W;

  typedef enum logic [2:0] {
    S_ACC,
    S_ERR,
    S_DIV,
    S_RD,
    S_LOAD
  } state_t;

  state_t                            state_r;
  logic [W-1:0]                      acc_r;
  logic [rsc_pkg::STAT_W-1:0]        err_r;
  logic [W-1:0]                      val_r;
  logic [BW-1:0]                     rem_r;
  logic [rsc_pkg::BIT_CNT_W-1:0]     bit_r;
  logic [rsc_pkg::DIG_CNT_W-1:0]     cnt_r;
  logic [rsc_pkg::DIG_IDX_W-1:0]     rd_idx_r;
  logic [BW-1:0]                     digit_buf_r [W];
  logic [BW-1:0]                     rd_data_r;
  logic                              out_valid_r;
  logic [rsc_pkg::CHAR_W-1:0]        out_char_r;
  logic                              out_last_r;
  logic [rsc_pkg::STAT_W-1:0]        out_status_r;

  logic [BW-1:0]                     sb, db;
  logic [W+BW-1:0]                   prod;
  logic [W+BW:0]                     sum;
  logic                              ovf;
  logic [rsc_pkg::STAT_W-1:0]        err_nxt;
  logic [W-1:0]                      acc_nxt;
  logic [BW:0]                       shifted;
  logic                              ge;
  logic [BW-1:0]                     rem_nxt;
  logic [W-1:0]                      val_nxt;
  logic                              div_done;
  logic                              out_free;
  logic                              out_load;
  logic                              buf_we;

  function automatic logic [7:0] digit_char(input logic [BW-1:0] d);
    logic [7:0] c;
    if (d < BW'(10)) c = 8'h30 + {2'b00, d};
    else c = 8'h41 + {2'b00, d - BW'(10)};
    return c;
  endfunction

  assign sb = rsc_pkg::clamp_base(source_base);
  assign db = rsc_pkg::clamp_base(dest_base);

  // Multiply-add with overflow taken from the bits above the value width.
  assign prod = acc_r * sb;
  assign sum  = {1'b0, prod} + (W+BW+1)'(item.digit);
  assign ovf  = |sum[W+BW:W];

  always_comb begin
    err_nxt = err_r;
    acc_nxt = acc_r;
    if (err_r == rsc_pkg::STAT_OK) begin
      if (item.bad) err_nxt = rsc_pkg::STAT_BAD_CHAR;
      else if (ovf) err_nxt = rsc_pkg::STAT_OVERFLOW;
      else acc_nxt = sum[W-1:0];
    end
  end

  // One quotient bit per cycle, restoring division by the destination base.
  assign shifted  = {rem_r, val_r[W-1]};
  assign ge       = (shifted >= {1'b0, db});
  assign rem_nxt  = ge ? BW'(shifted - {1'b0, db}) : shifted[BW-1:0];
  assign val_nxt  = {val_r[W-2:0], ge};
  assign div_done = (bit_r == rsc_pkg::BIT_CNT_W'(W - 1));

  assign item_pop  = (state_r == S_ACC) && !item_empty;
  assign out_free  = !out_valid_r || out_pop;
  assign out_load  = out_free && ((state_r == S_ERR) || (state_r == S_LOAD));
  assign buf_we    = (state_r == S_DIV) && div_done;

  assign out_empty  = !out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  always_ff @(posedge clk) begin
    if (buf_we) digit_buf_r[cnt_r[rsc_pkg::DIG_IDX_W-1:0]] <= rem_nxt;
    if (state_r == S_RD) rd_data_r <= digit_buf_r[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      acc_r       <= '0;
      err_r       <= rsc_pkg::STAT_OK;
      cnt_r       <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_pop);
      unique case (state_r)
        S_ACC: begin
          if (!item_empty) begin
            if (item.last) begin
              acc_r <= '0;
              if (err_nxt != rsc_pkg::STAT_OK) begin
                err_r   <= err_nxt;
                state_r <= S_ERR;
              end else begin
                val_r   <= acc_nxt;
                rem_r   <= '0;
                bit_r   <= '0;
                cnt_r   <= '0;
                state_r <= S_DIV;
              end
            end else begin
              acc_r <= acc_nxt;
              err_r <= err_nxt;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_char_r   <= '0;
            out_last_r   <= 1'b1;
            out_status_r <= err_r;
            err_r        <= rsc_pkg::STAT_OK;
            state_r      <= S_ACC;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cnt_r <= cnt_r + 1'b1;
            bit_r <= '0;
            rem_r <= '0;
            val_r <= val_nxt;
            if (val_nxt == '0) begin
              rd_idx_r <= cnt_r[rsc_pkg::DIG_IDX_W-1:0];
              state_r  <= S_RD;
            end
          end else begin
            bit_r <= bit_r + 1'b1;
            rem_r <= rem_nxt;
            val_r <= val_nxt;
          end
        end
        S_RD: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_char_r   <= digit_char(rd_data_r);
            out_last_r   <= (rd_idx_r == '0);
            out_status_r <= rsc_pkg::STAT_OK;
            if (rd_idx_r == '0) begin
              cnt_r   <= '0;
              state_r <= S_ACC;
            end else begin
              rd_idx_r <= rd_idx_r - 1'b1;
              state_r  <= S_RD;
            end
          end
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

endmodule

// ===== bench/radix_string_converter_core_test.sv =====
`timescale 1ns / 1ps

localparam logic [rsc_pkg::CHAR_W-1:0] CH_ZERO = "0";
localparam logic [rsc_pkg::CHAR_W-1:0] CH_NINE = "9";
localparam logic [rsc_pkg::CHAR_W-1:0] CH_UP_A = "A";
localparam logic [rsc_pkg::CHAR_W-1:0] CH_UP_Z = "Z";
localparam logic [rsc_pkg::CHAR_W-1:0] CH_LO_A = "a";
localparam logic [rsc_pkg::CHAR_W-1:0] CH_LO_Z = "z";

localparam logic [rsc_pkg::BASE_W-1:0] DEST_AT_RESET = rsc_pkg::BASE_W'(16);

typedef struct packed {
  logic [rsc_pkg::CHAR_W-1:0] ch;
  logic                       last;
  logic [rsc_pkg::STAT_W-1:0] status;
} conv_result_t;

class digit_scoreboard;
  logic [rsc_pkg::BASE_W-1:0]      src_reg;
  logic [rsc_pkg::BASE_W-1:0]      dst_reg;
  logic [rsc_pkg::VALUE_WIDTH-1:0] acc;
  logic [rsc_pkg::STAT_W-1:0]      run_status;
  conv_result_t                    owed_q[$];
  int                              errors;

  function new();
    src_reg    = rsc_pkg::BASE_TEN;
    dst_reg    = DEST_AT_RESET;
    acc        = '0;
    run_status = rsc_pkg::STAT_OK;
    errors     = 0;
  endfunction

  function void write_reg(logic [rsc_pkg::CFG_IDX_W-1:0] idx,
                          logic [rsc_pkg::BASE_W-1:0] data);
    case (idx)
      rsc_pkg::REG_SOURCE_BASE: src_reg = data;
      rsc_pkg::REG_DEST_BASE:   dst_reg = data;
      default: ;
    endcase
  endfunction

  function int clamp(logic [rsc_pkg::BASE_W-1:0] b);
    if (b < rsc_pkg::BASE_MIN) return int'(rsc_pkg::BASE_MIN);
    if (b > rsc_pkg::BASE_MAX) return int'(rsc_pkg::BASE_MAX);
    return int'(b);
  endfunction

  // Below ten only the digits under the base pass; from ten up any letter passes.
  function int char_value(logic [rsc_pkg::CHAR_W-1:0] c, int base);
    if (base < rsc_pkg::BASE_TEN) begin
      if (c < CH_ZERO || c >= CH_ZERO + base) return -1;
      return c - CH_ZERO;
    end
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 10;
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 10;
    return -1;
  endfunction

  function logic [rsc_pkg::CHAR_W-1:0] glyph(int d);
    return (d < 10) ? rsc_pkg::CHAR_W'(CH_ZERO + d) : rsc_pkg::CHAR_W'(CH_UP_A + d - 10);
  endfunction

  function int pending();
    return owed_q.size();
  endfunction

  function void note_char(logic [rsc_pkg::CHAR_W-1:0] c, logic last);
    int                              sb;
    int                              db;
    int                              d;
    logic [rsc_pkg::VALUE_WIDTH+6:0] sum;
    logic [rsc_pkg::VALUE_WIDTH-1:0] v;
    int                              digs[$];
    sb = clamp(src_reg);
    db = clamp(dst_reg);
    // first error of a run sticks; later characters leave the value alone
    if (run_status == rsc_pkg::STAT_OK) begin
      d = char_value(c, sb);
      if (d < 0) begin
        run_status = rsc_pkg::STAT_BAD_CHAR;
      end else begin
        sum = acc * sb + d;
        if (sum[rsc_pkg::VALUE_WIDTH+6:rsc_pkg::VALUE_WIDTH] != 0) begin
          run_status = rsc_pkg::STAT_OVERFLOW;
        end else begin
          acc = sum[rsc_pkg::VALUE_WIDTH-1:0];
        end
      end
    end
    if (!last) return;
    if (run_status != rsc_pkg::STAT_OK) begin
      owed_q.insert(owed_q.size(),
                    conv_result_t'{ch: '0, last: 1'b1, status: run_status});
    end else begin
      v = acc;
      do begin
        digs.insert(0, int'(v % db));
        v = v / db;
      end while (v != 0 && digs.size() < 64);
      foreach (digs[i])
        owed_q.insert(owed_q.size(),
                      conv_result_t'{ch: glyph(digs[i]), last: (i == digs.size() - 1),
                                     status: rsc_pkg::STAT_OK});
    end
    acc        = '0;
    run_status = rsc_pkg::STAT_OK;
  endfunction

  function void check_result(logic [rsc_pkg::CHAR_W-1:0] ch, logic last,
                             logic [rsc_pkg::STAT_W-1:0] status);
    conv_result_t want;
    if (owed_q.size() == 0) begin
      $error("result with nothing owed: out_char=%h out_last=%b out_status=%0d",
             ch, last, status);
      errors++;
      return;
    end
    want = owed_q.pop_front();
    if (ch !== want.ch) begin
      $error("out_char: expected %h, got %h", want.ch, ch);
      errors++;
    end
    if (last !== want.last) begin
      $error("out_last: expected %b, got %b", want.last, last);
      errors++;
    end
    if (status !== want.status) begin
      $error("out_status: expected %0d, got %0d", want.status, status);
      errors++;
    end
  endfunction
endclass

module radix_string_converter_core_test;

  // Longest quiet stretch: a 64-digit conversion runs one quotient bit per
  // cycle for every digit before the first digit can leave, plus stalls.
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LINGER_CYCLES = 300;
  localparam int PHASE_ITEMS   = 15;
  localparam int PHASES        = 8;

  localparam logic [rsc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = rsc_pkg::CFG_IDX_W'(2);
  localparam logic [rsc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = rsc_pkg::CFG_IDX_W'(3);

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_push   = 1'b0;
  logic                          in_full;
  logic [rsc_pkg::CHAR_W-1:0]    in_char   = '0;
  logic                          in_last   = 1'b0;
  logic                          out_empty;
  logic                          out_pop   = 1'b0;
  logic [rsc_pkg::CHAR_W-1:0]    out_char;
  logic                          out_last;
  logic [rsc_pkg::STAT_W-1:0]    out_status;
  logic                          cfg_we    = 1'b0;
  logic [rsc_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [rsc_pkg::BASE_W-1:0]    cfg_wdata = '0;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int quiet_cycles  = 0;
  int items_pushed  = 0;

  digit_scoreboard ledger = new();

  always #2 clk = ~clk;

  radix_string_converter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_char    (in_char),
    .in_last    (in_last),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_char   (out_char),
    .out_last   (out_last),
    .out_status (out_status),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  // Receiver: decide the pop for the next edge once per edge, so a stall
  // can land on any cycle of a conversion.
  always @(posedge clk) begin
    out_pop <= (pop_stall_pct == 0) || ($urandom_range(99) >= pop_stall_pct);
  end

  // Sample at the edge, before this edge's updates land. Every transfer on
  // either side feeds the scoreboard; any transfer or register write also
  // resets the watchdog.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) ledger.note_char(in_char, in_last);
    if (rst_n && out_pop && !out_empty) ledger.check_result(out_char, out_last, out_status);
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("radix_string_converter_core regression: fail");
      $finish;
    end
  end

  // Offer one character and hold it until the transfer. Idle cycles drop
  // push first; a held push is never lowered and raised in one step.
  task automatic push_char(input logic [rsc_pkg::CHAR_W-1:0] c, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_char <= c;
    in_last <= last;
    do @(posedge clk); while (in_full);
    items_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // Drop push, wait for every owed result, then let the pipe go quiet.
  task automatic drain(input int settle);
    in_push <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Write both bases back to back with cfg_we held high; optionally poke an
  // unused index, which the block must ignore.
  task automatic program_bases(input logic [rsc_pkg::BASE_W-1:0] src,
                               input logic [rsc_pkg::BASE_W-1:0] dst,
                               input bit poke_spare);
    logic [rsc_pkg::CFG_IDX_W-1:0] spare;
    logic [rsc_pkg::BASE_W-1:0]    junk;
    spare = $urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO;
    junk  = rsc_pkg::BASE_W'($urandom_range(63));
    cfg_we    <= 1'b1;
    cfg_idx   <= rsc_pkg::REG_SOURCE_BASE;
    cfg_wdata <= src;
    @(posedge clk);
    ledger.write_reg(rsc_pkg::REG_SOURCE_BASE, src);
    cfg_idx   <= rsc_pkg::REG_DEST_BASE;
    cfg_wdata <= dst;
    @(posedge clk);
    ledger.write_reg(rsc_pkg::REG_DEST_BASE, dst);
    if (poke_spare) begin
      cfg_idx   <= spare;
      cfg_wdata <= junk;
      @(posedge clk);
      ledger.write_reg(spare, junk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [rsc_pkg::CHAR_W-1:0] input_glyph(int d);
    if (d < 10) return rsc_pkg::CHAR_W'(CH_ZERO + d);
    return rsc_pkg::CHAR_W'(($urandom_range(1) ? CH_LO_A : CH_UP_A) + d - 10);
  endfunction

  // One number, ending on a last character. Mostly short well-formed runs;
  // some near the top of the value range (a few past it), some zero runs
  // with leading zeros, some with a stray byte, some pure noise.
  task automatic send_run();
    int                              sb;
    int                              fit;
    int                              kind;
    int                              len;
    int                              bad_at;
    int                              d;
    logic [rsc_pkg::VALUE_WIDTH-1:0] v;
    logic [rsc_pkg::CHAR_W-1:0]      c;
    sb  = ledger.clamp(ledger.src_reg);
    v   = '1;
    fit = 0;
    while (v != 0) begin
      v = v / sb;
      fit++;
    end
    kind   = $urandom_range(99);
    bad_at = -1;
    if (kind < 55) len = $urandom_range(1, 6);
    else if (kind < 65) len = $urandom_range(fit - 1, fit + 1);
    else if (kind < 78) len = $urandom_range(1, 4);
    else if (kind < 92) begin
      len    = $urandom_range(1, 6);
      bad_at = $urandom_range(len - 1);
    end else len = $urandom_range(1, 3);
    for (int i = 0; i < len; i++) begin
      if (kind >= 92 || i == bad_at) begin
        c = rsc_pkg::CHAR_W'($urandom_range(255));
      end else if (kind >= 65 && kind < 78) begin
        c = (i == len - 1 && $urandom_range(1)) ? input_glyph($urandom_range(sb - 1)) : CH_ZERO;
      end else begin
        d = $urandom_range(sb - 1);
        // long runs start with a nonzero digit so one past the fit overflows
        if (kind >= 55 && kind < 65 && i == 0) d = $urandom_range(1, sb - 1);
        // from base ten up, letters beyond the base are still taken
        if (sb >= rsc_pkg::BASE_TEN && $urandom_range(7) == 0) d = $urandom_range(35);
        c = input_glyph(d);
      end
      push_char(c, i == len - 1);
    end
  endtask

  initial begin
    int                         phase_start;
    logic [rsc_pkg::BASE_W-1:0] phase_src[PHASES];
    logic [rsc_pkg::BASE_W-1:0] phase_dst[PHASES];

    phase_src = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd8, 6'd1, 6'd0, 6'd0};
    phase_dst = '{6'd16, 6'd36, 6'd2, 6'd10, 6'd2, 6'd37, 6'd0, 6'd0};
    for (int p = PHASES - 2; p < PHASES; p++) begin
      phase_src[p] = rsc_pkg::BASE_W'($urandom_range(63));
      phase_dst[p] = rsc_pkg::BASE_W'($urandom_range(63));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset bases first (ten in, sixteen out), zero and a plain value.
    push_text("0");
    push_text("255");
    drain(SETTLE_CYCLES);
    // Base two in, over-range destination; a bad digit mid-run must stick.
    program_bases(6'd2, 6'd63, 1'b1);
    push_text("1201");
    drain(SETTLE_CYCLES);
    // Both bases under the minimum clamp to two.
    program_bases(6'd0, 6'd0, 1'b0);
    push_text("11");
    drain(SETTLE_CYCLES);
    // Base thirty-six both ways, both letter cases, then a 64-bit overflow.
    program_bases(6'd63, 6'd36, 1'b0);
    push_text("zZ");
    push_text("zzzzzzzzzzzzz");
    drain(SETTLE_CYCLES);
    // Base ten takes a letter; a top-bit byte is rejected.
    program_bases(6'd10, 6'd2, 1'b1);
    push_text("a");
    push_char(8'hFF, 1'b1);
    drain(SETTLE_CYCLES);

    // Random phases: new bases each phase, idling pattern rotates.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 51;
          pop_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 51;
        end
        default: begin
          send_idle_pct = 37;
          pop_stall_pct = 37;
        end
      endcase
      program_bases(phase_src[p], phase_dst[p], p[0]);
      phase_start = items_pushed;
      while (items_pushed - phase_start < PHASE_ITEMS) begin
        send_run();
        // now and then hold off until the block has emptied out
        if ($urandom_range(15) == 0) drain(0);
      end
      drain(SETTLE_CYCLES);
    end

    send_idle_pct = 0;
    pop_stall_pct = 0;
    drain(LINGER_CYCLES);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("radix_string_converter_core regression: pass");
    end else begin
      $display("radix_string_converter_core regression: fail");
    end
    $finish;
  end

endmodule
